FILE: rtl/cal_table_bilinear_interp_assert.svh
// Assertion macros shared by the RTL.
// Each expects clock and reset in scope; reset disables checking.
`ifndef CAL_TABLE_BILINEAR_INTERP_ASSERT_SVH
`define CAL_TABLE_BILINEAR_INTERP_ASSERT_SVH

// Same-cycle implication.
`define CTBI_ASSERT_IMPLY(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define CTBI_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/ctbi_pkg.sv
`default_nettype none

package ctbi_pkg;

   localparam int PWR_IN_W   = 15;
   localparam int FREQ_IN_W  = 16;
   localparam int OFFSET_W   = 13;
   localparam int SUM_PWR_W  = 16;
   localparam int VPD_W      = 11;

   localparam int FREQ_BASE   = 5600;
   localparam int FREQ_STEP   = 50;
   localparam int PWR_BASE_DB = 10;

   // col = (fo * FREQ_RECIP) >> FREQ_RECIP_SH, exact for fo up to 50*31
   localparam int FREQ_RECIP    = 1311;
   localparam int FREQ_RECIP_W  = 11;
   localparam int FREQ_RECIP_SH = 16;

   // q = (x * DIV50_RECIP) >> DIV50_SH, exact for x below 2^17
   localparam int DIV50_RECIP   = 167773;
   localparam int DIV50_RECIP_W = 18;
   localparam int DIV50_SH      = 23;

   localparam int ROM_ROWS = 17;
   localparam int ROM_COLS = 9;
   localparam int ROM_MAX  = 1465;

   localparam logic [VPD_W-1:0] VPD_ROM [0:ROM_ROWS-1][0:ROM_COLS-1] = '{
      '{11'd415,  11'd375,  11'd375,  11'd380,  11'd380,  11'd380,  11'd395,  11'd390,  11'd400},
      '{11'd420,  11'd420,  11'd400,  11'd400,  11'd405,  11'd425,  11'd430,  11'd440,  11'd435},
      '{11'd470,  11'd455,  11'd445,  11'd445,  11'd455,  11'd465,  11'd485,  11'd490,  11'd490},
      '{11'd525,  11'd510,  11'd490,  11'd490,  11'd500,  11'd515,  11'd540,  11'd550,  11'd545},
      '{11'd575,  11'd565,  11'd555,  11'd545,  11'd560,  11'd575,  11'd595,  11'd600,  11'd600},
      '{11'd640,  11'd630,  11'd610,  11'd610,  11'd625,  11'd645,  11'd665,  11'd675,  11'd670},
      '{11'd730,  11'd710,  11'd685,  11'd680,  11'd690,  11'd725,  11'd750,  11'd755,  11'd755},
      '{11'd805,  11'd785,  11'd755,  11'd755,  11'd770,  11'd805,  11'd830,  11'd840,  11'd835},
      '{11'd905,  11'd875,  11'd850,  11'd845,  11'd860,  11'd895,  11'd910,  11'd930,  11'd935},
      '{11'd1020, 11'd995,  11'd955,  11'd945,  11'd960,  11'd995,  11'd1030, 11'd1045, 11'd1055},
      '{11'd1180, 11'd1115, 11'd1075, 11'd1065, 11'd1080, 11'd1125, 11'd1150, 11'd1175, 11'd1165},
      '{11'd1335, 11'd1260, 11'd1230, 11'd1210, 11'd1235, 11'd1260, 11'd1295, 11'd1310, 11'd1320},
      '{11'd1415, 11'd1395, 11'd1355, 11'd1355, 11'd1355, 11'd1390, 11'd1395, 11'd1400, 11'd1390},
      '{11'd1440, 11'd1430, 11'd1430, 11'd1430, 11'd1435, 11'd1435, 11'd1440, 11'd1430, 11'd1425},
      '{11'd1440, 11'd1440, 11'd1450, 11'd1445, 11'd1450, 11'd1450, 11'd1450, 11'd1440, 11'd1435},
      '{11'd1450, 11'd1450, 11'd1450, 11'd1455, 11'd1450, 11'd1450, 11'd1450, 11'd1450, 11'd1435},
      '{11'd1450, 11'd1450, 11'd1450, 11'd1455, 11'd1465, 11'd1460, 11'd1460, 11'd1450, 11'd1445}
   };

   // Entries outside the stored grid read as zero.
   function automatic logic [VPD_W-1:0] vpd_rom_read(input logic [4:0] row,
                                                     input logic [4:0] col);
      logic [VPD_W-1:0] val;
      val = '0;
      if ((row < 5'(ROM_ROWS)) && (col < 5'(ROM_COLS))) begin
         val = VPD_ROM[row][col[3:0]];
      end
      return val;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/cal_table_bilinear_interp.sv
`default_nettype none
// Calibration-table setpoint lookup with bilinear interpolation.
// Input channel: an item (req_power_db in 1/256 dB, req_freq_mhz in MHz) transfers at a
// rising edge with start high and busy low. busy is always low: the pipeline takes one
// item every cycle, back to back.
// Result channel: rsp_valid is high for exactly one cycle with rsp_vpd_setpoint and
// rsp_clamped; the receiver cannot stall, so nothing waits and nothing is dropped.
// Pipeline: ten register stages, the first loaded at the accepting edge: offset add,
// clamp, row/column split, column correction, table read, two multiply stages, sum,
// divide-by-12800 reciprocal multiply, output. Throughput is one item per cycle, set by
// the fully pipelined datapath; the table is constant logic read at four corners per cycle.
// Configuration: csr_wr_en writes csr_wr_data into the signed power offset (1/256 dB).
// Write only while no items are in flight.
// Reset (synchronous, active high) clears the offset to zero and all stage valid bits;
// items in flight are discarded.
module cal_table_bilinear_interp
   import ctbi_pkg::*;
#(
   parameter int FREQ_POINTS  = 9,
   parameter int POWER_POINTS = 17
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   output logic                             busy,
   input  wire logic signed [PWR_IN_W-1:0]  req_power_db,
   input  wire logic        [FREQ_IN_W-1:0] req_freq_mhz,
   input  wire logic                        csr_wr_en,
   input  wire logic signed [OFFSET_W-1:0]  csr_wr_data,
   output logic                             rsp_valid,
   output logic             [VPD_W-1:0]     rsp_vpd_setpoint,
   output logic                             rsp_clamped
);

`include "cal_table_bilinear_interp_assert.svh"

   // clamp window and derived widths
   localparam int PR_MAX  = (POWER_POINTS - 1) * 256;
   localparam int FO_MAX  = FREQ_STEP * (FREQ_POINTS - 1);
   localparam int PR_W    = $clog2(PR_MAX + 1);
   localparam int FO_W    = $clog2(FO_MAX + 1);
   localparam int ROW_W   = $clog2(POWER_POINTS);
   localparam int COL_W   = $clog2(FREQ_POINTS);
   localparam int ROWR_W  = PR_W - 8;
   localparam int CPROD_W = FO_W + FREQ_RECIP_W;
   localparam int COLR_W  = CPROD_W - FREQ_RECIP_SH;
   localparam int WX_W    = 9;
   localparam int WY_W    = 6;
   localparam int T_W     = VPD_W + WX_W;
   localparam int U_W     = T_W + WY_W;
   localparam int S_W     = U_W + 1;
   localparam int X_W     = S_W - 8;
   localparam int QP_W    = X_W + DIV50_RECIP_W;
   localparam int DX_EXT_W = PR_W + 1;

   localparam logic signed [SUM_PWR_W-1:0] PWR_LO =
      SUM_PWR_W'(PWR_BASE_DB * 256);
   localparam logic signed [SUM_PWR_W-1:0] PWR_HI =
      SUM_PWR_W'((PWR_BASE_DB + POWER_POINTS - 1) * 256);
   localparam logic [FREQ_IN_W-1:0] F_LO = FREQ_IN_W'(FREQ_BASE);
   localparam logic [FREQ_IN_W-1:0] F_HI = FREQ_IN_W'(FREQ_BASE + FO_MAX);

   assign busy = 1'b0;

   // ---------------------------------------------------------------- offset register
   logic signed [OFFSET_W-1:0] offset_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= '0;
      end else if (csr_wr_en) begin
         offset_ff <= csr_wr_data;
      end
   end

   // ---------------------------------------------------------------- stage 1: offset add
   logic                        s1_valid_ff;
   logic signed [SUM_PWR_W-1:0] s1_power_ff;
   logic signed [SUM_PWR_W-1:0] s1_power_in;
   logic        [FREQ_IN_W-1:0] s1_freq_ff;

   assign s1_power_in = $signed({req_power_db[PWR_IN_W-1], req_power_db})
                      + $signed({{(SUM_PWR_W-OFFSET_W){offset_ff[OFFSET_W-1]}}, offset_ff});

   // ---------------------------------------------------------------- stage 2: clamp
   logic                        s2_valid_ff;
   logic        [PR_W-1:0]      s2_pr_ff, s2_pr_in;
   logic        [FO_W-1:0]      s2_fo_ff, s2_fo_in;
   logic                        s2_clamped_ff, s2_clamped_in;
   logic signed [SUM_PWR_W-1:0] s2_pc;
   logic        [FREQ_IN_W-1:0] s2_fc;
   logic signed [SUM_PWR_W-1:0] s2_pdiff;
   logic        [FREQ_IN_W-1:0] s2_fdiff;

   always_comb begin
      s2_clamped_in = 1'b0;
      s2_pc         = s1_power_ff;
      s2_fc         = s1_freq_ff;
      // in-window values pass through untouched
      if (s1_power_ff < PWR_LO) begin
         s2_pc         = PWR_LO;
         s2_clamped_in = 1'b1;
      end else if (s1_power_ff > PWR_HI) begin
         s2_pc         = PWR_HI;
         s2_clamped_in = 1'b1;
      end
      if (s1_freq_ff < F_LO) begin
         s2_fc         = F_LO;
         s2_clamped_in = 1'b1;
      end else if (s1_freq_ff > F_HI) begin
         s2_fc         = F_HI;
         s2_clamped_in = 1'b1;
      end
      s2_pdiff = s2_pc - PWR_LO;
      s2_fdiff = s2_fc - F_LO;
      s2_pr_in = s2_pdiff[PR_W-1:0];
      s2_fo_in = s2_fdiff[FO_W-1:0];
   end

   // ---------------------------------------------------------------- stage 3: row split, column estimate
   logic                  s3_valid_ff;
   logic [ROW_W-1:0]      s3_row_ff, s3_row_in;
   logic [WX_W-1:0]       s3_dx_ff, s3_dx_in;
   logic [CPROD_W-1:0]    s3_cprod_ff, s3_cprod_in;
   logic [FO_W-1:0]       s3_fo_ff;
   logic                  s3_clamped_ff;
   logic [ROWR_W-1:0]     s3_row_raw;
   logic [DX_EXT_W-1:0]   s3_dx_ext;

   always_comb begin
      s3_row_raw = s2_pr_ff[PR_W-1:8];
      if (ROW_W'(s3_row_raw) > ROW_W'(POWER_POINTS - 2)) begin
         s3_row_in = ROW_W'(POWER_POINTS - 2);
      end else begin
         s3_row_in = ROW_W'(s3_row_raw);
      end
      s3_dx_ext   = DX_EXT_W'(s2_pr_ff) - DX_EXT_W'({s3_row_in, 8'h00});
      s3_dx_in    = s3_dx_ext[WX_W-1:0];
      s3_cprod_in = CPROD_W'(s2_fo_ff) * CPROD_W'(FREQ_RECIP);
   end

   // ---------------------------------------------------------------- stage 4: column clip, dy
   logic              s4_valid_ff;
   logic [ROW_W-1:0]  s4_row_ff;
   logic [WX_W-1:0]   s4_dx_ff;
   logic [COL_W-1:0]  s4_col_ff, s4_col_in;
   logic [WY_W-1:0]   s4_dy_ff, s4_dy_in;
   logic              s4_clamped_ff;
   logic [COLR_W-1:0] s4_col_raw;
   logic [FO_W-1:0]   s4_dy_ext;

   always_comb begin
      s4_col_raw = s3_cprod_ff[CPROD_W-1:FREQ_RECIP_SH];
      if (COLR_W'(s4_col_raw) > COLR_W'(FREQ_POINTS - 2)) begin
         s4_col_in = COL_W'(FREQ_POINTS - 2);
      end else begin
         s4_col_in = COL_W'(s4_col_raw);
      end
      s4_dy_ext = s3_fo_ff - FO_W'(FO_W'(s4_col_in) * FO_W'(FREQ_STEP));
      s4_dy_in  = s4_dy_ext[WY_W-1:0];
   end

   // ---------------------------------------------------------------- stage 5: corner read, weights
   logic             s5_valid_ff;
   logic [VPD_W-1:0] s5_q11_ff, s5_q12_ff, s5_q21_ff, s5_q22_ff;
   logic [WX_W-1:0]  s5_dx_ff, s5_wx_ff;
   logic [WY_W-1:0]  s5_dy_ff, s5_wy_ff;
   logic             s5_clamped_ff;
   logic [4:0]       s5_r0, s5_r1, s5_c0, s5_c1;

   assign s5_r0 = 5'(s4_row_ff);
   assign s5_r1 = 5'(s4_row_ff) + 5'd1;
   assign s5_c0 = 5'(s4_col_ff);
   assign s5_c1 = 5'(s4_col_ff) + 5'd1;

   // ---------------------------------------------------------------- stage 6: power-axis products
   logic             s6_valid_ff;
   logic [T_W-1:0]   s6_t11_ff, s6_t12_ff, s6_t21_ff, s6_t22_ff;
   logic [WY_W-1:0]  s6_dy_ff, s6_wy_ff;
   logic             s6_clamped_ff;

   // ---------------------------------------------------------------- stage 7: freq-axis products
   logic             s7_valid_ff;
   logic [U_W-1:0]   s7_u11_ff, s7_u12_ff, s7_u21_ff, s7_u22_ff;
   logic             s7_clamped_ff;

   // ---------------------------------------------------------------- stage 8: sum
   logic             s8_valid_ff;
   logic [S_W-1:0]   s8_sum_ff;
   logic             s8_clamped_ff;

   // ---------------------------------------------------------------- stage 9: /50 reciprocal
   // sum/12800 = (sum >> 8) / 50
   logic             s9_valid_ff;
   logic [QP_W-1:0]  s9_qprod_ff;
   logic             s9_clamped_ff;

   // ---------------------------------------------------------------- output register
   logic             rsp_valid_ff;
   logic [VPD_W-1:0] rsp_vpd_ff;
   logic             rsp_clamped_ff;

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         s5_valid_ff  <= 1'b0;
         s6_valid_ff  <= 1'b0;
         s7_valid_ff  <= 1'b0;
         s8_valid_ff  <= 1'b0;
         s9_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= start && !busy;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         s4_valid_ff  <= s3_valid_ff;
         s5_valid_ff  <= s4_valid_ff;
         s6_valid_ff  <= s5_valid_ff;
         s7_valid_ff  <= s6_valid_ff;
         s8_valid_ff  <= s7_valid_ff;
         s9_valid_ff  <= s8_valid_ff;
         rsp_valid_ff <= s9_valid_ff;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      s1_power_ff   <= s1_power_in;
      s1_freq_ff    <= req_freq_mhz;

      s2_pr_ff      <= s2_pr_in;
      s2_fo_ff      <= s2_fo_in;
      s2_clamped_ff <= s2_clamped_in;

      s3_row_ff     <= s3_row_in;
      s3_dx_ff      <= s3_dx_in;
      s3_cprod_ff   <= s3_cprod_in;
      s3_fo_ff      <= s2_fo_ff;
      s3_clamped_ff <= s2_clamped_ff;

      s4_row_ff     <= s3_row_ff;
      s4_dx_ff      <= s3_dx_ff;
      s4_col_ff     <= s4_col_in;
      s4_dy_ff      <= s4_dy_in;
      s4_clamped_ff <= s3_clamped_ff;

      s5_q11_ff     <= vpd_rom_read(s5_r0, s5_c0);
      s5_q12_ff     <= vpd_rom_read(s5_r0, s5_c1);
      s5_q21_ff     <= vpd_rom_read(s5_r1, s5_c0);
      s5_q22_ff     <= vpd_rom_read(s5_r1, s5_c1);
      s5_dx_ff      <= s4_dx_ff;
      s5_wx_ff      <= WX_W'(256) - s4_dx_ff;
      s5_dy_ff      <= s4_dy_ff;
      s5_wy_ff      <= WY_W'(FREQ_STEP) - s4_dy_ff;
      s5_clamped_ff <= s4_clamped_ff;

      s6_t11_ff     <= T_W'(s5_q11_ff) * T_W'(s5_wx_ff);
      s6_t12_ff     <= T_W'(s5_q12_ff) * T_W'(s5_wx_ff);
      s6_t21_ff     <= T_W'(s5_q21_ff) * T_W'(s5_dx_ff);
      s6_t22_ff     <= T_W'(s5_q22_ff) * T_W'(s5_dx_ff);
      s6_dy_ff      <= s5_dy_ff;
      s6_wy_ff      <= s5_wy_ff;
      s6_clamped_ff <= s5_clamped_ff;

      s7_u11_ff     <= U_W'(s6_t11_ff) * U_W'(s6_wy_ff);
      s7_u21_ff     <= U_W'(s6_t21_ff) * U_W'(s6_wy_ff);
      s7_u12_ff     <= U_W'(s6_t12_ff) * U_W'(s6_dy_ff);
      s7_u22_ff     <= U_W'(s6_t22_ff) * U_W'(s6_dy_ff);
      s7_clamped_ff <= s6_clamped_ff;

      s8_sum_ff     <= S_W'(s7_u11_ff) + S_W'(s7_u21_ff)
                     + S_W'(s7_u12_ff) + S_W'(s7_u22_ff);
      s8_clamped_ff <= s7_clamped_ff;

      s9_qprod_ff   <= QP_W'(s8_sum_ff[S_W-1:8]) * QP_W'(DIV50_RECIP);
      s9_clamped_ff <= s8_clamped_ff;

      rsp_vpd_ff     <= s9_qprod_ff[DIV50_SH +: VPD_W];
      rsp_clamped_ff <= s9_clamped_ff;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_vpd_setpoint = rsp_vpd_ff;
   assign rsp_clamped      = rsp_clamped_ff;

   // ---------------------------------------------------------------- checks
   `CTBI_ASSERT_NEXT(a_last_stage_to_rsp, s9_valid_ff, rsp_valid_ff, "result strobe lost")
   `CTBI_ASSERT_IMPLY(a_pr_in_window, s2_valid_ff,
      s2_pr_ff <= PR_W'(PR_MAX), "power outside window")
   `CTBI_ASSERT_IMPLY(a_cell_offsets, s4_valid_ff,
      (s4_dx_ff <= WX_W'(256)) && (s4_dy_ff <= WY_W'(FREQ_STEP)), "cell offset out of range")
   `CTBI_ASSERT_IMPLY(a_setpoint_bound, rsp_valid_ff,
      rsp_vpd_ff <= VPD_W'(ROM_MAX), "setpoint above table")

endmodule

`default_nettype wire

FILE: tb/sv/setpoint_checker.sv
// Watches the lookup channels, predicts each setpoint and compares it field by field.
module setpoint_checker
   import ctbi_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic                        busy,
   input  logic signed [PWR_IN_W-1:0]  req_power_db,
   input  logic        [FREQ_IN_W-1:0] req_freq_mhz,
   input  logic                        csr_wr_en,
   input  logic signed [OFFSET_W-1:0]  csr_wr_data,
   input  logic                        rsp_valid,
   input  logic        [VPD_W-1:0]     rsp_vpd_setpoint,
   input  logic                        rsp_clamped,
   output int                          mismatch_count,
   output int                          outstanding
);

   localparam int PWR_LO_Q8  = 10 * 256;
   localparam int PWR_HI_Q8  = 26 * 256;
   localparam int F_LO       = 5600;
   localparam int F_HI       = 6000;
   localparam int F_STEP     = 50;
   localparam int LAST_ROW   = 15;
   localparam int LAST_COL   = 7;

   // Detector voltage grid: rows 10..26 dB, columns 5600..6000 MHz.
   localparam int VPD_GRID [0:16][0:8] = '{
      '{415,  375,  375,  380,  380,  380,  395,  390,  400},
      '{420,  420,  400,  400,  405,  425,  430,  440,  435},
      '{470,  455,  445,  445,  455,  465,  485,  490,  490},
      '{525,  510,  490,  490,  500,  515,  540,  550,  545},
      '{575,  565,  555,  545,  560,  575,  595,  600,  600},
      '{640,  630,  610,  610,  625,  645,  665,  675,  670},
      '{730,  710,  685,  680,  690,  725,  750,  755,  755},
      '{805,  785,  755,  755,  770,  805,  830,  840,  835},
      '{905,  875,  850,  845,  860,  895,  910,  930,  935},
      '{1020, 995,  955,  945,  960,  995,  1030, 1045, 1055},
      '{1180, 1115, 1075, 1065, 1080, 1125, 1150, 1175, 1165},
      '{1335, 1260, 1230, 1210, 1235, 1260, 1295, 1310, 1320},
      '{1415, 1395, 1355, 1355, 1355, 1390, 1395, 1400, 1390},
      '{1440, 1430, 1430, 1430, 1435, 1435, 1440, 1430, 1425},
      '{1440, 1440, 1450, 1445, 1450, 1450, 1450, 1440, 1435},
      '{1450, 1450, 1450, 1455, 1450, 1450, 1450, 1450, 1435},
      '{1450, 1450, 1450, 1455, 1465, 1460, 1460, 1450, 1445}
   };

   typedef struct packed {
      logic [VPD_W-1:0] vpd;
      logic             clamped;
   } setpoint_type;

   setpoint_type               setpoint_q[$];
   logic signed [OFFSET_W-1:0] offset_reg;

   function automatic setpoint_type lookup_setpoint(
         input logic signed [PWR_IN_W-1:0]  pwr,
         input logic        [FREQ_IN_W-1:0] frq,
         input logic signed [OFFSET_W-1:0]  ofs);
      int           p, f, row, col, dx, dy, acc;
      setpoint_type r;
      p = int'(pwr) + int'(ofs);
      f = int'(frq);
      r.clamped = 1'b0;
      if (p < PWR_LO_Q8) begin p = PWR_LO_Q8; r.clamped = 1'b1; end
      if (p > PWR_HI_Q8) begin p = PWR_HI_Q8; r.clamped = 1'b1; end
      if (f < F_LO) begin f = F_LO; r.clamped = 1'b1; end
      if (f > F_HI) begin f = F_HI; r.clamped = 1'b1; end
      // upper edges fall into the last cell with full weight on its far corners
      row = (p - PWR_LO_Q8) / 256;
      if (row > LAST_ROW) row = LAST_ROW;
      dx  = (p - PWR_LO_Q8) - row * 256;
      col = (f - F_LO) / F_STEP;
      if (col > LAST_COL) col = LAST_COL;
      dy  = (f - F_LO) - col * F_STEP;
      acc = VPD_GRID[row][col]       * (256 - dx) * (F_STEP - dy)
          + VPD_GRID[row+1][col]     * dx         * (F_STEP - dy)
          + VPD_GRID[row][col+1]     * (256 - dx) * dy
          + VPD_GRID[row+1][col+1]   * dx         * dy;
      acc = acc / (256 * F_STEP);
      r.vpd = VPD_W'(acc);
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("mismatch: %s", msg);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      setpoint_type want;
      if (reset) begin
         offset_reg <= '0;
         setpoint_q.delete();
         outstanding <= 0;
      end else begin
         if (rsp_valid) begin
            if (setpoint_q.size() == 0) begin
               report_mismatch($sformatf("result %0d/%0d with nothing expected",
                                         rsp_vpd_setpoint, rsp_clamped));
            end else begin
               want = setpoint_q.pop_front();
               if (rsp_vpd_setpoint !== want.vpd)
                  report_mismatch($sformatf("vpd_setpoint got %0d expected %0d",
                                            rsp_vpd_setpoint, want.vpd));
               if (rsp_clamped !== want.clamped)
                  report_mismatch($sformatf("clamped got %0b expected %0b",
                                            rsp_clamped, want.clamped));
            end
         end
         if (start && !busy)
            setpoint_q.push_back(lookup_setpoint(req_power_db, req_freq_mhz, offset_reg));
         if (csr_wr_en) offset_reg <= csr_wr_data;
         outstanding <= setpoint_q.size();
      end
   end

endmodule

FILE: tb/sv/tb_top.sv
// Stimulus and verdict for the bilinear setpoint lookup.
// The checker beside the DUT does all prediction and comparison.
module tb_top;
   import ctbi_pkg::*;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int DRAIN_CYCLES  = 20;      // pipeline is 10 deep
   localparam int PHASE_ITEMS   = 270;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        start = 1'b0;
   logic                        busy;
   logic signed [PWR_IN_W-1:0]  req_power_db = '0;
   logic        [FREQ_IN_W-1:0] req_freq_mhz = '0;
   logic                        csr_wr_en = 1'b0;
   logic signed [OFFSET_W-1:0]  csr_wr_data = '0;
   logic                        rsp_valid;
   logic        [VPD_W-1:0]     rsp_vpd_setpoint;
   logic                        rsp_clamped;

   int mismatch_count;
   int outstanding;
   int cycle_count = 0;
   bit gaps_on = 1'b0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   cal_table_bilinear_interp #(
      .FREQ_POINTS  (9),
      .POWER_POINTS (17)
   ) i_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_power_db     (req_power_db),
      .req_freq_mhz     (req_freq_mhz),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .rsp_valid        (rsp_valid),
      .rsp_vpd_setpoint (rsp_vpd_setpoint),
      .rsp_clamped      (rsp_clamped)
   );

   setpoint_checker i_checker (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_power_db     (req_power_db),
      .req_freq_mhz     (req_freq_mhz),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .rsp_valid        (rsp_valid),
      .rsp_vpd_setpoint (rsp_vpd_setpoint),
      .rsp_clamped      (rsp_clamped),
      .mismatch_count   (mismatch_count),
      .outstanding      (outstanding)
   );

   // Watchdog: a hung handshake or a lost result ends up here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // One lookup transfer. An optional idle burst with start low may go first;
   // start is held high across back-to-back transfers and only the fields change.
   task automatic send_lookup(input logic signed [PWR_IN_W-1:0]  pwr,
                              input logic        [FREQ_IN_W-1:0] frq);
      int gap;
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 3);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start        <= 1'b1;
      req_power_db <= pwr;
      req_freq_mhz <= frq;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // Offset write with the pipe empty; every transfer yields a result, so an
   // empty expectation queue means nothing is in flight.
   task automatic write_offset(input logic signed [OFFSET_W-1:0] ofs);
      start <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (2) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= ofs;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Mostly inside or just around the table, some anywhere in the stated
   // range and a few raw bit patterns.
   function automatic logic signed [PWR_IN_W-1:0] pick_power();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel < 7)       return PWR_IN_W'($urandom_range(2300, 6900));
      else if (sel < 9)  return PWR_IN_W'(int'($urandom_range(0, 20479)) - 4096);
      else               return PWR_IN_W'($urandom_range(0, 32767));
   endfunction

   function automatic logic [FREQ_IN_W-1:0] pick_freq();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel < 7)       return FREQ_IN_W'($urandom_range(5550, 6050));
      else if (sel == 7) return FREQ_IN_W'(5600 + 50 * $urandom_range(0, 8));
      else if (sel == 8) return FREQ_IN_W'($urandom_range(0, 65535));
      else               return FREQ_IN_W'($urandom_range(5600, 6000));
   endfunction

   initial begin
      logic signed [OFFSET_W-1:0] offsets [0:5];
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: offset at its reset value of zero.
      send_lookup(2560, 5600);      // bottom-left grid corner
      send_lookup(6656, 6000);      // top edge in both axes: last cell, far corner
      send_lookup(6656, 5600);
      send_lookup(2560, 6000);
      send_lookup(2559, 5800);      // just under 10 dB
      send_lookup(6657, 5800);      // just over the top row
      send_lookup(4000, 5599);      // just under the band
      send_lookup(4000, 6001);      // just over the band
      send_lookup(-16384, 0);       // most negative power, zero frequency
      send_lookup(16383, 65535);    // most positive power, all-ones frequency
      send_lookup(-4096, 5700);     // stated power floor
      send_lookup(6400, 5650);      // on row and column boundaries
      send_lookup(6655, 5999);      // just inside the top corner
      send_lookup(4321, 5625);      // mid-cell
      send_lookup(3000, 5950);
      send_lookup(5555, 5975);
      send_lookup(0, 5800);
      send_lookup(-1, 32768);

      // Random phases, each under its own offset: both ends of the stated
      // range, a random value, the 13-bit extremes, and back to zero.
      offsets[0] = -2560;
      offsets[1] = 2560;
      offsets[2] = OFFSET_W'(int'($urandom_range(0, 5120)) - 2560);
      offsets[3] = -4096;
      offsets[4] = 4095;
      offsets[5] = 0;
      for (int ph = 0; ph < 6; ph++) begin
         write_offset(offsets[ph]);
         // edge points under the new offset
         send_lookup(2560, 6000);
         send_lookup(6656, 5600);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // gaps come and go in stretches; the last phase runs flat out
            if (n % 40 == 0) gaps_on = (ph < 5) && ($urandom_range(0, 2) != 0);
            send_lookup(pick_power(), pick_freq());
         end
      end

      start <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
